// ===== src/sbm_pkg.sv =====
// Shared types, widths and the level threshold table of the stereo bar meter.
package sbm_pkg;

  localparam int SAMPLE_W             = 12;
  localparam int LEVEL_W              = 5;
  localparam int PATTERN_W            = 10;
  localparam int COUNT_W              = 8;
  localparam int TABLE_SIZE           = 16;
  localparam int NUM_SEGMENTS_DEFAULT = 10;

  typedef logic [SAMPLE_W-1:0]         sample_t;
  typedef logic signed [LEVEL_W-1:0]   level_t;
  typedef logic [PATTERN_W-1:0]        pattern_t;
  typedef logic [COUNT_W-1:0]          count_t;
  typedef logic [COUNT_W-1:0]          hold_t;

  localparam level_t LEVEL_NONE       = -5'sd1;
  localparam hold_t  HOLD_TICKS_RESET = 8'd100;
  localparam count_t COUNT_TOP        = '1;

  // Ascending thresholds; entries past the tenth sit at full scale and never trip.
  localparam sample_t LEVEL_TABLE [TABLE_SIZE] = '{
    12'd20,   12'd200,  12'd632,  12'd893,  12'd1125, 12'd1416, 12'd1783, 12'd2000,
    12'd2825, 12'd4000, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095
  };

endpackage

// ===== src/sbm_tick_if.sv =====
// Input channel: one display tick carrying one converter sample.
interface sbm_tick_if;
  logic             valid;
  logic             ready;
  sbm_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== src/sbm_bar_if.sv =====
// Output channel: one bar display result per tick.
interface sbm_bar_if;
  logic              valid;
  logic              ready;
  sbm_pkg::pattern_t bar_pattern;
  sbm_pkg::level_t   bar_level;
  logic              peak_shown;
  logic              served_channel;

  modport source (output valid, output bar_pattern, output bar_level,
                  output peak_shown, output served_channel, input ready);
  modport sink   (input valid, input bar_pattern, input bar_level,
                  input peak_shown, input served_channel, output ready);
endinterface

// ===== src/sbm_quant.sv =====
// Sample quantizer: parallel strict compares against the threshold table.
module sbm_quant #(
  parameter int NumSegments = sbm_pkg::NUM_SEGMENTS_DEFAULT
) (
  input  sbm_pkg::sample_t sample,
  output sbm_pkg::level_t  level
);
  import sbm_pkg::*;

  // Table is ascending, so the highest tripped threshold gives the level.
  always_comb begin
    level = LEVEL_NONE;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (i < NumSegments && sample > LEVEL_TABLE[i]) begin
        level = level_t'(LEVEL_W'(i));
      end
    end
  end

endmodule

// ===== src/stereo_bar_meter_peak_hold_core.sv =====
// Top level of the stereo bar meter with per-channel peak hold.
// Each tick passes through the input register, then the result register,
//   which drives the result.
//   Throughput: one tick per clock, sustained while the output side takes results.
// The result register frees the input side while a result waits to be taken.
// Reset (rst, synchronous): channel pointer to 0 so the first tick serves
//   channel 1, both peaks to -1, both hold counters to 0, hold_ticks to 100.
module stereo_bar_meter_peak_hold_core #(
  parameter int NUM_SEGMENTS = sbm_pkg::NUM_SEGMENTS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  sbm_tick_if.sink        tick,
  sbm_bar_if.source       bar,
  input  logic            cfg_we,
  input  sbm_pkg::hold_t  cfg_wdata
);
  import sbm_pkg::*;

  // Configuration register.
  hold_t    hold_ticks;

  // Input register stage.
  logic     s1_valid;
  sample_t  s1_sample;

  // Result register stage.
  logic     res_valid;
  pattern_t res_pattern;
  level_t   res_level;
  logic     res_shown;
  logic     res_channel;

  // Per-channel meter state.
  logic     current_channel;
  level_t   held_peak [2];
  count_t   hold_counter [2];

  // Work stage signals.
  logic     advance;
  logic     ch;
  level_t   level;
  level_t   peak_cur;
  count_t   cnt_inc;
  logic     below;
  logic     show;
  level_t   held_peak_next;
  count_t   hold_counter_next;
  pattern_t pattern_next;

  // Move the input register into the result register when the result slot
  // is empty or being drained this cycle.
  assign advance    = s1_valid && (!res_valid || bar.ready);
  assign tick.ready = !s1_valid || advance;

  // Served channel toggles each tick; the new value is the one served.
  assign ch = ~current_channel;

  sbm_quant #(
    .NumSegments(NUM_SEGMENTS)
  ) u_quant (
    .sample(s1_sample),
    .level (level)
  );

  always_comb begin
    peak_cur = held_peak[ch];
    // Count this tick, saturating at the top.
    cnt_inc  = (hold_counter[ch] == COUNT_TOP) ? hold_counter[ch]
                                               : hold_counter[ch] + 1'b1;
    below    = level < peak_cur;
    show     = below && (cnt_inc < hold_ticks);

    // A level at or above the peak takes over; an expired hold drops the peak.
    if (!below) begin
      held_peak_next    = level;
      hold_counter_next = '0;
    end else if (show) begin
      held_peak_next    = peak_cur;
      hold_counter_next = cnt_inc;
    end else begin
      held_peak_next    = LEVEL_NONE;
      hold_counter_next = '0;
    end

    // Fill bits up to the level, then add the held dot when shown.
    for (int i = 0; i < PATTERN_W; i++) begin
      pattern_next[i] = (level >= $signed(LEVEL_W'(i)))
                      || (show && (peak_cur == $signed(LEVEL_W'(i))));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks      <= HOLD_TICKS_RESET;
      s1_valid        <= 1'b0;
      res_valid       <= 1'b0;
      current_channel <= 1'b0;
      held_peak[0]    <= LEVEL_NONE;
      held_peak[1]    <= LEVEL_NONE;
      hold_counter[0] <= '0;
      hold_counter[1] <= '0;
    end else begin
      if (cfg_we) begin
        hold_ticks <= cfg_wdata;
      end

      // Input register: take a transfer, or drop the item once it advances.
      if (tick.valid && tick.ready) begin
        s1_valid  <= 1'b1;
        s1_sample <= tick.sample;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      // Result register and state commit.
      if (advance) begin
        res_valid        <= 1'b1;
        res_pattern      <= pattern_next;
        res_level        <= level;
        res_shown        <= show;
        res_channel      <= ch;
        current_channel  <= ch;
        held_peak[ch]    <= held_peak_next;
        hold_counter[ch] <= hold_counter_next;
      end else if (bar.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign bar.valid          = res_valid;
  assign bar.bar_pattern    = res_pattern;
  assign bar.bar_level      = res_level;
  assign bar.peak_shown     = res_shown;
  assign bar.served_channel = res_channel;

endmodule

// ===== dv/tb_stereo_bar_meter_peak_hold_core.sv =====
// Self-checking testbench for the stereo bar meter core with per-channel peak hold.
`timescale 1ns / 100ps

module tb_stereo_bar_meter_peak_hold_core;
  import sbm_pkg::*;

  localparam int NUM_SEG       = 10;
  localparam int SETTLE_CYCLES = 6;     // result latency plus margin
  localparam int IDLE_LIMIT    = 4000;  // cycles with no transfer before giving up
  localparam int PHASE_ITEMS   = 120;

  // One expected bar display result.
  typedef struct packed {
    pattern_t pattern;
    level_t   level;
    logic     shown;
    logic     channel;
  } bar_t;

  logic clk;
  logic rst;
  logic cfg_we;
  hold_t cfg_wdata;

  sbm_tick_if tick ();
  sbm_bar_if  bar ();

  stereo_bar_meter_peak_hold_core dut (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick.sink),
    .bar       (bar.source),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the meter state: channel pointer, per-channel peak and dwell count,
  // and the hold setting currently in the register.
  logic   chan_ptr;
  level_t peak_lvl [2];
  count_t dwell_cnt [2];
  hold_t  hold_limit;

  bar_t pending_bars [$];
  int   mismatches;
  int   sent_items;
  int   idle_cycles;
  int   ready_hold;
  bit   calm;   // when set, neither side inserts gaps

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Lower edge of each level step; a sample strictly above it reaches that level.
  function automatic int threshold_of(int i);
    case (i)
      0: return 20;
      1: return 200;
      2: return 632;
      3: return 893;
      4: return 1125;
      5: return 1416;
      6: return 1783;
      7: return 2000;
      8: return 2825;
      default: return 4000;
    endcase
  endfunction

  // Advance the mirrored meter by one tick and return the bar it should display.
  function automatic bar_t meter_predict(sample_t s);
    bar_t r;
    int   lvl;
    int   ch;
    int   pk;
    chan_ptr = ~chan_ptr;
    ch = chan_ptr;
    lvl = -1;
    for (int i = 0; i < NUM_SEG; i++) begin
      if (s > threshold_of(i)) lvl = i;
    end
    r.pattern = '0;
    for (int i = 0; i < NUM_SEG; i++) begin
      if (i <= lvl) r.pattern[i] = 1'b1;
    end
    // Saturate the dwell count instead of wrapping.
    if (dwell_cnt[ch] != COUNT_TOP) dwell_cnt[ch] = dwell_cnt[ch] + 1'b1;
    pk = peak_lvl[ch];
    r.shown = 1'b0;
    if (lvl < pk) begin
      if (dwell_cnt[ch] < hold_limit) begin
        // Keep the dot lit at the held peak.
        r.shown = 1'b1;
        r.pattern[pk] = 1'b1;
      end else begin
        // Hold expired: drop the peak.
        dwell_cnt[ch] = '0;
        peak_lvl[ch] = LEVEL_NONE;
      end
    end else begin
      // Equal or higher level takes over the peak and restarts the hold.
      peak_lvl[ch] = level_t'(lvl);
      dwell_cnt[ch] = '0;
    end
    r.level = level_t'(lvl);
    r.channel = chan_ptr;
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random sample that quantizes to the given level (-1 for below the first step).
  function automatic sample_t sample_for_level(int lvl);
    int hi;
    if (lvl < 0) return sample_t'($urandom_range(0, threshold_of(0)));
    hi = (lvl == NUM_SEG - 1) ? 4095 : threshold_of(lvl + 1);
    return sample_t'($urandom_range(threshold_of(lvl) + 1, hi));
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Present one sample, hold it until transferred, then record its expected bar.
  task automatic send_sample(input sample_t s);
    int gap;
    tick.valid <= 1'b1;
    tick.sample <= s;
    @(posedge clk);
    while (tick.ready !== 1'b1) @(posedge clk);
    pending_bars.push_back(meter_predict(s));
    sent_items++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      tick.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every expected bar has come out and the pipe is empty.
  task automatic wait_all_bars();
    tick.valid <= 1'b0;
    while (pending_bars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the hold register while the core is idle.
  task automatic set_hold_ticks(input hold_t v);
    wait_all_bars();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    hold_limit = v;
    cfg_we <= 1'b0;
  endtask

  // Output side: take results under random back-pressure and compare each one
  // with the oldest pending expectation.
  always @(posedge clk) begin
    bar_t want;
    if (bar.valid === 1'b1 && bar.ready === 1'b1) begin
      if (pending_bars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual pattern %h level %0d",
                 $time, bar.bar_pattern, bar.bar_level);
      end else begin
        want = pending_bars.pop_front();
        check_field("bar_pattern", want.pattern, bar.bar_pattern);
        check_field("bar_level", $signed(want.level), $signed(bar.bar_level));
        check_field("peak_shown", want.shown, bar.peak_shown);
        check_field("served_channel", want.channel, bar.served_channel);
      end
    end
    if (rst === 1'b1) begin
      bar.ready <= 1'b0;
    end else if (calm) begin
      bar.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      bar.ready <= 1'b0;
    end else begin
      bar.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) ready_hold = pick_gap();
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((tick.valid === 1'b1 && tick.ready === 1'b1) ||
        (bar.valid === 1'b1 && bar.ready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Reset hold setting of 100; samples at both ends of the range and on each
  // side of every step edge.
  task automatic test_step_edges();
    send_sample(sample_t'(0));
    send_sample(sample_t'(4095));
    for (int i = 0; i < NUM_SEG; i++) begin
      send_sample(sample_t'(threshold_of(i)));
      send_sample(sample_t'(threshold_of(i) + 1));
    end
  endtask

  // Peak dot life at short, zero and one-tick hold settings.
  task automatic test_short_holds();
    // Hold of three: dot lingers for two ticks of the channel, then drops.
    set_hold_ticks(hold_t'(3));
    send_sample(sample_for_level(8));
    send_sample(sample_for_level(6));
    for (int i = 0; i < 6; i++) begin
      send_sample(sample_for_level(2));
      send_sample(sample_for_level(-1));
    end
    // Equal level refreshes the peak and restarts the hold.
    send_sample(sample_for_level(5));
    send_sample(sample_for_level(5));
    send_sample(sample_for_level(5));
    send_sample(sample_for_level(5));
    send_sample(sample_for_level(3));
    send_sample(sample_for_level(4));
    // Hold of zero: a lower level clears the peak at once.
    set_hold_ticks(hold_t'(0));
    send_sample(sample_for_level(9));
    send_sample(sample_for_level(9));
    send_sample(sample_for_level(1));
    send_sample(sample_for_level(0));
    send_sample(sample_for_level(-1));
    send_sample(sample_for_level(-1));
    // Hold of one behaves the same way as a hold of zero.
    set_hold_ticks(hold_t'(1));
    send_sample(sample_for_level(7));
    send_sample(sample_for_level(7));
    send_sample(sample_for_level(2));
    send_sample(sample_for_level(2));
    send_sample(sample_for_level(1));
    send_sample(sample_for_level(1));
  endtask

  // Longest hold: dot must stay lit until the dwell count reaches the top.
  task automatic test_longest_hold();
    set_hold_ticks(hold_t'(255));
    send_sample(sample_for_level(9));
    send_sample(sample_for_level(9));
    for (int i = 0; i < 262; i++) begin
      send_sample(sample_for_level(int'($urandom_range(0, 9)) - 1));
      send_sample(sample_for_level(int'($urandom_range(0, 9)) - 1));
    end
    // Pause the sender until every result is out.
    wait_all_bars();
  endtask

  // Random traffic in phases, one hold setting per phase.
  task automatic test_random_traffic();
    int holds [8];
    int h;
    int start;
    int p;
    int top;
    int run;
    holds = '{1, 255, 0, 2, -1, 100, -1, 6};
    for (int ph = 0; ph < 8; ph++) begin
      h = (holds[ph] < 0) ? $urandom_range(1, 254) : holds[ph];
      set_hold_ticks(hold_t'(h));
      calm = (ph == 5);
      start = sent_items;
      while (sent_items < start + PHASE_ITEMS) begin
        p = $urandom_range(0, 99);
        if (p < 70) begin
          // Burst on both channels, then a decay that may outlive the hold.
          top = $urandom_range(0, 9);
          send_sample(sample_for_level(top));
          send_sample(sample_for_level(int'($urandom_range(0, 10)) - 1));
          run = $urandom_range(1, (h + 4 > 40) ? 40 : h + 4);
          for (int i = 0; i < run; i++) begin
            send_sample(sample_for_level(int'($urandom_range(0, top + 1)) - 1));
            send_sample(sample_for_level(int'($urandom_range(0, top + 1)) - 1));
          end
        end else if (p < 85) begin
          // Noise over the whole sample range.
          run = $urandom_range(1, 8);
          for (int i = 0; i < run; i++) send_sample(sample_t'($urandom_range(0, 4095)));
        end else begin
          // Samples hugging a step edge.
          run = $urandom_range(1, 6);
          for (int i = 0; i < run; i++) begin
            send_sample(sample_t'(threshold_of($urandom_range(0, NUM_SEG - 1))
                                  + $urandom_range(0, 2) - 1));
          end
        end
        if (ph == 3 && sent_items >= start + PHASE_ITEMS / 2 &&
            sent_items < start + PHASE_ITEMS / 2 + 4) begin
          wait_all_bars();
        end
      end
      calm = 1'b0;
    end
  endtask

  initial begin
    // Drive every input to a known value with reset held, then release reset.
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    tick.valid <= 1'b0;
    tick.sample <= '0;
    chan_ptr = 1'b0;
    peak_lvl[0] = LEVEL_NONE;
    peak_lvl[1] = LEVEL_NONE;
    dwell_cnt[0] = '0;
    dwell_cnt[1] = '0;
    hold_limit = HOLD_TICKS_RESET;
    mismatches = 0;
    sent_items = 0;
    idle_cycles = 0;
    ready_hold = 0;
    calm = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_step_edges();
    test_short_holds();
    test_longest_hold();
    test_random_traffic();

    // Drain and let any stray result show up before judging.
    wait_all_bars();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
